// ===== hw/rtl/amtd_pkg.sv =====
// amtd_pkg: shared types and constants of the adaptive threshold detector
// no dependencies; imported by the controller, the datapath, the top level and the checker

package amtd_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int GAIN_BITS    = 6;
  localparam int ALPHA_BITS   = 16;
  localparam int LINE_BITS    = 3;
  localparam int INDEX_BITS   = 48;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // rounding constant: one half of the alpha scale
  localparam int ROUND_HALF = 1 << (ALPHA_BITS - 1);

  // register reset values
  localparam logic [CHANNEL_BITS-1:0] CHANNEL_RESET = '0;
  localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = GAIN_BITS'(8);
  localparam logic [ALPHA_BITS-1:0]   ALPHA_RESET   = ALPHA_BITS'(655);
  localparam logic [LINE_BITS-1:0]    LINE_RESET    = '0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MONITORED_CHANNEL = 2'd0,
    REG_GAIN_HALVES       = 2'd1,
    REG_SMOOTHING_FACTOR  = 2'd2,
    REG_TTL_LINE          = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_DIFF,
    ST_MEAN_MUL,
    ST_MEAN_UPD,
    ST_DEV_ABS,
    ST_DEV_DIFF,
    ST_DEV_MUL,
    ST_DEV_UPD,
    ST_DECIDE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MEAN_DIFF,
    OP_MUL,
    OP_MEAN_UPD,
    OP_DEV_ABS,
    OP_DEV_DIFF,
    OP_DEV_UPD,
    OP_DECIDE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic track;     // loaded word is tracked and the mean is already seeded
    logic out_busy;  // result register holds a word that is not taken this cycle
  } dp_status_t;

endpackage

// ===== hw/rtl/amtd_ctrl.sv =====
// amtd_ctrl: sequencer that steps the datapath through one tracked sample
// depends on amtd_pkg

module amtd_ctrl import amtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (status.track) begin
            state_next = ST_MEAN_DIFF;
          end
        end
      end
      ST_MEAN_DIFF: begin
        cmd.op     = OP_MEAN_DIFF;
        state_next = ST_MEAN_MUL;
      end
      ST_MEAN_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_MEAN_UPD;
      end
      ST_MEAN_UPD: begin
        cmd.op     = OP_MEAN_UPD;
        state_next = ST_DEV_ABS;
      end
      ST_DEV_ABS: begin
        cmd.op     = OP_DEV_ABS;
        state_next = ST_DEV_DIFF;
      end
      ST_DEV_DIFF: begin
        cmd.op     = OP_DEV_DIFF;
        state_next = ST_DEV_MUL;
      end
      ST_DEV_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_DEV_UPD;
      end
      ST_DEV_UPD: begin
        cmd.op     = OP_DEV_UPD;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.op = OP_DECIDE;
        // wait here while the result register is still occupied
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/amtd_dp.sv =====
// amtd_dp: running averages, shared alpha multiplier, threshold compare and result register
// depends on amtd_pkg; driven by amtd_ctrl

module amtd_dp import amtd_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  logic                          state_clear,
  input  logic [CHANNEL_BITS-1:0]       monitored_channel,
  input  logic [GAIN_BITS-1:0]          gain_halves,
  input  logic [ALPHA_BITS-1:0]         smoothing_factor,
  input  logic [LINE_BITS-1:0]          ttl_line,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CHANNEL_BITS-1:0]       channel,
  input  logic [INDEX_BITS-1:0]         sample_index,
  input  logic                          restart,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          event_level,
  output logic [INDEX_BITS-1:0]         event_sample,
  output logic [LINE_BITS-1:0]          event_line
);

  localparam int W  = SAMPLE_BITS + FRACTION_BITS;
  localparam int PW = W + 1 + ALPHA_BITS;

  // running state
  logic [W-1:0] mean_average;       // signed
  logic [W-1:0] deviation_average;  // unsigned
  logic         seeded;
  logic         above_flag;

  // per-sample working registers
  logic [W-1:0]          xf;
  logic [INDEX_BITS-1:0] index_hold;
  logic [W-1:0]          dev_abs;
  logic                  diff_neg;
  logic [W:0]            diff_mag;
  logic [PW-1:0]         product;

  logic [W-1:0]    xf_in;
  logic            match;
  logic            seeded_eff;
  logic            out_busy;
  logic [W:0]      mean_diff;
  logic [W:0]      dev_diff;
  logic [W:0]      sel_diff;
  logic [W:0]      neg_diff;
  logic [PW-1:0]   rounded;
  logic [W+1:0]    delta_mag;
  logic [W+1:0]    delta;
  logic [W+1:0]    acc_sel;
  logic [W+1:0]    acc_sum;
  logic [W-1:0]    twice_xf;
  logic [W+GAIN_BITS-1:0] thresh;
  logic            above;
  logic            decide_go;

  assign xf_in      = {sample, {FRACTION_BITS{1'b0}}};
  assign match      = (channel == monitored_channel);
  assign seeded_eff = seeded && !restart;
  assign out_busy   = out_valid && !out_ready;

  assign status.track    = match && seeded_eff;
  assign status.out_busy = out_busy;

  // difference toward the target, sign and magnitude
  assign mean_diff = {xf[W-1], xf} - {mean_average[W-1], mean_average};
  assign dev_diff  = {1'b0, dev_abs} - {1'b0, deviation_average};
  assign sel_diff  = (cmd.op == OP_DEV_DIFF) ? dev_diff : mean_diff;
  assign neg_diff  = ~sel_diff + {{W{1'b0}}, 1'b1};

  // round half away from zero on the magnitude, then restore the sign
  assign rounded   = product + PW'(ROUND_HALF);
  assign delta_mag = {1'b0, rounded[PW-1:ALPHA_BITS]};
  assign delta     = diff_neg ? (~delta_mag + {{(W+1){1'b0}}, 1'b1}) : delta_mag;
  assign acc_sel   = (cmd.op == OP_DEV_UPD) ? {2'b00, deviation_average}
                                            : {{2{mean_average[W-1]}}, mean_average};
  assign acc_sum   = acc_sel + delta;

  // exact compare: 2 * xf against gain_halves * deviation_average
  assign twice_xf  = {xf[W-2:0], 1'b0};
  assign thresh    = {{GAIN_BITS{1'b0}}, deviation_average} *
                     {{W{1'b0}}, gain_halves};
  assign above     = !xf[W-1] && ({{GAIN_BITS{1'b0}}, twice_xf} > thresh);
  assign decide_go = (cmd.op == OP_DECIDE) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_average      <= '0;
      deviation_average <= '0;
      seeded            <= 1'b0;
      above_flag        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (state_clear) begin
        mean_average      <= '0;
        deviation_average <= '0;
        seeded            <= 1'b0;
        above_flag        <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (restart) begin
            mean_average      <= '0;
            deviation_average <= '0;
            seeded            <= 1'b0;
            above_flag        <= 1'b0;
          end
          // first tracked word only seeds the mean
          if (match && !seeded_eff) begin
            mean_average      <= xf_in;
            deviation_average <= '0;
            seeded            <= 1'b1;
          end
        end
        OP_MEAN_UPD: mean_average      <= acc_sum[W-1:0];
        OP_DEV_UPD:  deviation_average <= acc_sum[W-1:0];
        OP_DECIDE: begin
          if (decide_go) begin
            above_flag <= above;
          end
        end
        default: ;
      endcase
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (decide_go && (above != above_flag)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        xf         <= xf_in;
        index_hold <= sample_index;
      end
      OP_MEAN_DIFF, OP_DEV_DIFF: begin
        diff_neg <= sel_diff[W];
        diff_mag <= sel_diff[W] ? neg_diff : sel_diff;
      end
      OP_MUL: begin
        product <= PW'(diff_mag) * PW'(smoothing_factor);
      end
      OP_DEV_ABS: begin
        dev_abs <= sel_diff[W] ? neg_diff[W-1:0] : sel_diff[W-1:0];
      end
      OP_DECIDE: begin
        if (decide_go) begin
          event_level  <= above;
          event_sample <= index_hold;
          event_line   <= ttl_line;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/adaptive_mad_threshold_detector.sv =====
// adaptive_mad_threshold_detector: top level, configuration registers and unit wiring
// depends on amtd_pkg, amtd_ctrl and amtd_dp
//
//   channel   handshake            payload
//   input     in_valid/in_ready    sample, channel, sample_index, restart
//   output    out_valid/out_ready  event_level, event_sample, event_line
//   config    cfg_write            cfg_index, cfg_data (no ready, no read-back)
//
// a word on another channel, or one that only seeds the mean, leaves the sequencer in idle
// a tracked word is stepped through the mean and deviation updates before the next ready: the single
//   alpha multiplier is used twice in a row, once per average, each use being
//   difference, multiply, round-and-accumulate
// a full result register stalls the sequencer in its final step only
// synchronous active-high reset returns to idle with all averages cleared

module adaptive_mad_threshold_detector import amtd_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CHANNEL_BITS-1:0]       channel,
  input  logic [INDEX_BITS-1:0]         sample_index,
  input  logic                          restart,
  // event words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          event_level,
  output logic [INDEX_BITS-1:0]         event_sample,
  output logic [LINE_BITS-1:0]          event_line,
  // register writes
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  // configuration registers
  logic [CHANNEL_BITS-1:0] monitored_channel;
  logic [GAIN_BITS-1:0]    gain_halves;
  logic [ALPHA_BITS-1:0]   smoothing_factor;
  logic [LINE_BITS-1:0]    ttl_line;

  logic       state_clear;
  dp_cmd_t    cmd;
  dp_status_t status;

  // any write to the channel register restarts tracking
  assign state_clear = cfg_write && (cfg_reg_t'(cfg_index) == REG_MONITORED_CHANNEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      monitored_channel <= CHANNEL_RESET;
      gain_halves       <= GAIN_RESET;
      smoothing_factor  <= ALPHA_RESET;
      ttl_line          <= LINE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MONITORED_CHANNEL: monitored_channel <= cfg_data[CHANNEL_BITS-1:0];
        REG_GAIN_HALVES:       gain_halves       <= cfg_data[GAIN_BITS-1:0];
        REG_SMOOTHING_FACTOR:  smoothing_factor  <= cfg_data[ALPHA_BITS-1:0];
        REG_TTL_LINE:          ttl_line          <= cfg_data[LINE_BITS-1:0];
      endcase
    end
  end

  // sequencer: owns the input handshake, one datapath step per cycle unless the result is untaken
  amtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: averages in fixed point, threshold compare, result register
  amtd_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .state_clear       (state_clear),
    .monitored_channel (monitored_channel),
    .gain_halves       (gain_halves),
    .smoothing_factor  (smoothing_factor),
    .ttl_line          (ttl_line),
    .sample            (sample),
    .channel           (channel),
    .sample_index      (sample_index),
    .restart           (restart),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .event_level       (event_level),
    .event_sample      (event_sample),
    .event_line        (event_line)
  );

endmodule

// ===== hw/rtl/amtd_checker.sv =====
// amtd_checker: port-level assertions on the detector, attached by bind
// depends on amtd_pkg and adaptive_mad_threshold_detector

module amtd_checker import amtd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic [CHANNEL_BITS-1:0]       channel,
  input logic [INDEX_BITS-1:0]         sample_index,
  input logic                          restart,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          event_level,
  input logic [INDEX_BITS-1:0]         event_sample,
  input logic [LINE_BITS-1:0]          event_line
);

  // a sample word that waits for ready holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(channel) &&
      $stable(sample_index) && $stable(restart))
    else $error("sample word changed while waiting");

  // a stalled event word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_level) &&
      $stable(event_sample) && $stable(event_line))
    else $error("event word changed while stalled");

  // reset leaves the block ready with no pending event
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // an event only appears at the end of a busy stretch
  a_event_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("event raised while input side was idle");

  // after a taken word, valid stays up only for a freshly decided event
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid || !$past(in_ready))
    else $error("event word repeated after handshake");

endmodule

bind adaptive_mad_threshold_detector amtd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_amtd_checker (.*);
